// File: hw/rtl/rqff_pkg.sv
// ----------------------------------------------------------------------------
// rqff_pkg: shared types of the read quality fragment filter
// Verdict codes, configuration register indexes and the structs that travel
// between the front, the summary queue and the back.
// ----------------------------------------------------------------------------
package rqff_pkg;

  // Number of fragment banks. It is also the depth of the summary queue.
  localparam int unsigned NUM_BANKS = 2;

  // Fragment count field, wide enough for the largest fragment table.
  localparam int unsigned FRAG_CNT_W = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_QUALITY_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_SCALE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAGMENT_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_CHAR       = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_KEPT     = 2'd0,
    VERDICT_REJECT   = 2'd1,
    VERDICT_NO_FRAG  = 2'd2,
    VERDICT_TOO_LONG = 2'd3
  } rqff_verdict_e;

  typedef struct packed {
    logic [7:0] low_quality_char;
    logic [7:0] reject_scale;
    logic [8:0] min_fragment_len;
    logic [7:0] split_char;
  } rqff_cfg_t;

  // Write of one kept fragment into the fragment table.
  typedef struct packed {
    logic                  en;
    logic                  bank;
    logic [FRAG_CNT_W-1:0] idx;
    logic [7:0]            start;
    logic [8:0]            length;
  } rqff_frag_wr_t;

  // Outcome of one finished read.
  typedef struct packed {
    logic                  bank;
    logic [FRAG_CNT_W-1:0] count;
    rqff_verdict_e         verdict;
  } rqff_summary_t;

  // The back hands a fragment bank back to the front.
  typedef struct packed {
    logic valid;
    logic bank;
  } rqff_release_t;

  typedef struct packed {
    rqff_verdict_e verdict;
    logic [7:0]    start;
    logic [8:0]    length;
    logic          last;
  } rqff_result_t;

endpackage

// File: hw/rtl/rqff_front.sv
// ----------------------------------------------------------------------------
// rqff_front: per-base classification
// Counts low quality bases, tracks runs between split characters, writes
// kept runs to the fragment table and posts a summary at the end of a read.
// ----------------------------------------------------------------------------
module rqff_front #(
  parameter int unsigned MAX_READ  = 256,
  parameter int unsigned MAX_FRAGS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rqff_pkg::rqff_cfg_t    cfg_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [7:0]             base_char_i,
  input  logic [7:0]             quality_char_i,
  input  logic                   read_end_i,
  output rqff_pkg::rqff_frag_wr_t frag_wr_o,
  output logic                   sum_push_o,
  output rqff_pkg::rqff_summary_t sum_o,
  input  rqff_pkg::rqff_release_t release_i
);

  localparam int unsigned PW   = $clog2(MAX_READ + 1);
  localparam int unsigned LW   = PW + 8;
  localparam int unsigned CW   = (PW > 9) ? PW : 9;
  localparam int unsigned KW   = $clog2(MAX_FRAGS + 1);
  localparam int unsigned CntW = rqff_pkg::FRAG_CNT_W;
  localparam int unsigned NB   = rqff_pkg::NUM_BANKS;

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] run_start_q, run_start_d;
  logic [PW-1:0] run_len_q, run_len_d;
  logic [LW-1:0] low_prod_q, low_prod_d;
  logic [KW-1:0] kept_q, kept_d;
  logic          ovf_q, ovf_d;
  logic          bank_q, bank_d;
  logic [NB-1:0] busy_q, busy_d;

  logic          accept;
  logic          split_now;
  logic          close_req;
  logic [PW-1:0] close_len;
  logic          keep;
  logic [KW-1:0] kept_after;
  rqff_pkg::rqff_verdict_e verdict;

  always_comb begin
    pos_d       = pos_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    low_prod_d  = low_prod_q;
    kept_d      = kept_q;
    ovf_d       = ovf_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    split_now   = 1'b0;
    verdict     = rqff_pkg::VERDICT_KEPT;

    accept = push_i && !busy_q[bank_q];

    if (accept && !ovf_q) begin
      if (pos_q == PW'(MAX_READ)) begin
        ovf_d = 1'b1;
      end else begin
        if (quality_char_i < cfg_i.low_quality_char) begin
          low_prod_d = low_prod_q + LW'(cfg_i.reject_scale);
        end
        if (base_char_i == cfg_i.split_char) begin
          split_now   = 1'b1;
          run_start_d = pos_q + PW'(1);
          run_len_d   = '0;
        end else begin
          run_len_d = run_len_q + PW'(1);
        end
        pos_d = pos_q + PW'(1);
      end
    end

    // A split closes the previous run; the end of a read closes the current
    // one. Both at once leave an empty current run, so one close suffices.
    close_req  = accept && (split_now || (read_end_i && !ovf_d));
    close_len  = split_now ? run_len_q : run_len_d;
    keep       = close_req && (close_len != '0) &&
                 (CW'(close_len) >= CW'(cfg_i.min_fragment_len)) &&
                 (kept_q < KW'(MAX_FRAGS));
    kept_after = kept_q + KW'(keep);
    kept_d     = kept_after;

    if (ovf_d) begin
      verdict = rqff_pkg::VERDICT_TOO_LONG;
    end else if (low_prod_d > LW'(pos_d)) begin
      verdict = rqff_pkg::VERDICT_REJECT;
    end else if (kept_after == '0) begin
      verdict = rqff_pkg::VERDICT_NO_FRAG;
    end

    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end

    if (accept && read_end_i) begin
      busy_d[bank_q] = 1'b1;
      bank_d         = ~bank_q;
      pos_d          = '0;
      run_start_d    = '0;
      run_len_d      = '0;
      low_prod_d     = '0;
      kept_d         = '0;
      ovf_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      run_start_q <= '0;
      run_len_q   <= '0;
      low_prod_q  <= '0;
      kept_q      <= '0;
      ovf_q       <= 1'b0;
      bank_q      <= 1'b0;
      busy_q      <= '0;
    end else begin
      pos_q       <= pos_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      low_prod_q  <= low_prod_d;
      kept_q      <= kept_d;
      ovf_q       <= ovf_d;
      bank_q      <= bank_d;
      busy_q      <= busy_d;
    end
  end

  assign full_o = busy_q[bank_q];

  assign frag_wr_o.en     = keep;
  assign frag_wr_o.bank   = bank_q;
  assign frag_wr_o.idx    = CntW'(kept_q);
  assign frag_wr_o.start  = 8'(run_start_q);
  assign frag_wr_o.length = 9'(close_len);

  assign sum_push_o    = accept && read_end_i;
  assign sum_o.bank    = bank_q;
  assign sum_o.count   = CntW'(kept_after);
  assign sum_o.verdict = verdict;

  // An overflowed read records no fragments.
  a_ovf_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ovf_q) |-> !frag_wr_o.en)
    else $error("fragment written for an overflowed read");

endmodule

// File: hw/rtl/rqff_sum_fifo.sv
// ----------------------------------------------------------------------------
// rqff_sum_fifo: summary queue between front and back
// Two entries, one for each fragment bank.
// ----------------------------------------------------------------------------
module rqff_sum_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  rqff_pkg::rqff_summary_t data_i,
  input  logic                    pop_i,
  output logic                    valid_o,
  output rqff_pkg::rqff_summary_t data_o
);

  localparam int unsigned NB = rqff_pkg::NUM_BANKS;

  rqff_pkg::rqff_summary_t entry_q [NB];
  logic                    wr_ptr_q, wr_ptr_d;
  logic                    rd_ptr_q, rd_ptr_d;
  logic [1:0]              cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  // Bank ownership bounds the queue; a push into a full queue is a slip.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2) || pop_i)
    else $error("summary queue overflow");

endmodule

// File: hw/rtl/rqff_back.sv
// ----------------------------------------------------------------------------
// rqff_back: result emission
// Holds the two-bank fragment table, walks the kept fragments of each read
// summary and feeds a two-entry result queue.
// ----------------------------------------------------------------------------
module rqff_back #(
  parameter int unsigned MAX_FRAGS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rqff_pkg::rqff_frag_wr_t frag_wr_i,
  input  logic                    sum_valid_i,
  input  rqff_pkg::rqff_summary_t sum_i,
  output logic                    sum_pop_o,
  output rqff_pkg::rqff_release_t release_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output rqff_pkg::rqff_result_t  result_o
);

  localparam int unsigned Depth = rqff_pkg::NUM_BANKS * MAX_FRAGS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = rqff_pkg::FRAG_CNT_W;

  logic [7:0] mem_start [Depth];
  logic [8:0] mem_len   [Depth];

  logic [AW-1:0] waddr, raddr;
  logic [CntW-1:0] idx_q, idx_d;

  logic       st_valid_q;
  rqff_pkg::rqff_verdict_e st_verdict_q;
  logic       st_last_q;
  logic [7:0] rd_start_q;
  logic [8:0] rd_len_q;

  rqff_pkg::rqff_result_t ofifo_q [2];
  rqff_pkg::rqff_result_t push_word;
  logic       owr_ptr_q, ord_ptr_q;
  logic [1:0] ocnt_q, ocnt_d;

  logic pop_ok, room, issue, is_kept, last;

  assign waddr = frag_wr_i.bank ? (AW'(MAX_FRAGS) + AW'(frag_wr_i.idx)) : AW'(frag_wr_i.idx);
  assign raddr = sum_i.bank ? (AW'(MAX_FRAGS) + AW'(idx_q)) : AW'(idx_q);

  always_comb begin
    pop_ok  = pop_i && (ocnt_q != 2'd0);
    // Issue only if the result queue still has a place when the staged word
    // lands in it.
    room    = ({1'b0, ocnt_q} + {2'b0, st_valid_q}) <= (3'd1 + {2'b0, pop_ok});
    issue   = sum_valid_i && room;
    is_kept = (sum_i.verdict == rqff_pkg::VERDICT_KEPT);
    last    = !is_kept || ((idx_q + CntW'(1)) == sum_i.count);
    idx_d   = idx_q;
    if (issue) begin
      idx_d = last ? '0 : idx_q + CntW'(1);
    end
    ocnt_d = ocnt_q + 2'(st_valid_q) - 2'(pop_ok);

    push_word.verdict = st_verdict_q;
    push_word.last    = st_last_q;
    if (st_verdict_q == rqff_pkg::VERDICT_KEPT) begin
      push_word.start  = rd_start_q;
      push_word.length = rd_len_q;
    end else begin
      push_word.start  = '0;
      push_word.length = '0;
    end
  end

  assign sum_pop_o       = issue && last;
  assign release_o.valid = issue && last;
  assign release_o.bank  = sum_i.bank;

  always_ff @(posedge clk_i) begin
    if (frag_wr_i.en) begin
      mem_start[waddr] <= frag_wr_i.start;
      mem_len[waddr]   <= frag_wr_i.length;
    end
    if (issue && is_kept) begin
      rd_start_q <= mem_start[raddr];
      rd_len_q   <= mem_len[raddr];
    end
    if (issue) begin
      st_verdict_q <= sum_i.verdict;
      st_last_q    <= last;
    end
    if (st_valid_q) begin
      ofifo_q[owr_ptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      st_valid_q <= 1'b0;
      owr_ptr_q  <= 1'b0;
      ord_ptr_q  <= 1'b0;
      ocnt_q     <= '0;
    end else begin
      idx_q      <= idx_d;
      st_valid_q <= issue;
      owr_ptr_q  <= owr_ptr_q ^ st_valid_q;
      ord_ptr_q  <= ord_ptr_q ^ pop_ok;
      ocnt_q     <= ocnt_d;
    end
  end

  assign empty_o  = (ocnt_q == 2'd0);
  assign result_o = ofifo_q[ord_ptr_q];

  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_q && !pop_ok) |-> (ocnt_q != 2'd2))
    else $error("result queue overflow");

  a_kept_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid_i && (sum_i.verdict == rqff_pkg::VERDICT_KEPT)) |-> (sum_i.count != '0))
    else $error("kept verdict without fragments");

endmodule

// File: hw/rtl/read_quality_fragment_filter_top.sv
// ----------------------------------------------------------------------------
// read_quality_fragment_filter_top: read quality filter with fragment split
// Takes a read one base per word, rejects reads with too many low quality
// bases and reports the runs between split characters that are long enough.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   --------------------------------------
//   bases     push / full             base_char_i, quality_char_i, read_end_i
//   results   pop / empty             verdict_o, fragment_start_o,
//                                     fragment_length_o, last_of_read_o
//   config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The front takes one base word every cycle while full is low. At the final
// base it posts a summary of the read to a two-entry queue; the back then
// emits one result word per cycle while results are popped, through the
// fragment table read stage. The front stalls (full high) only at the start
// of a read when both fragment banks still hold reads that the back has not
// yet emitted. Reset clears all control state at once; there is no clearing
// pass, and results may be taken at any pace without losing base throughput
// until both banks are occupied.
// ----------------------------------------------------------------------------
module read_quality_fragment_filter_top #(
  parameter int unsigned MAX_READ  = 256,
  parameter int unsigned MAX_FRAGS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Base words.
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       base_char_i,
  input  logic [7:0]                       quality_char_i,
  input  logic                             read_end_i,
  // Result words.
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       verdict_o,
  output logic [7:0]                       fragment_start_o,
  output logic [8:0]                       fragment_length_o,
  output logic                             last_of_read_o,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rqff_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rqff_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce this, and writes are always taken.
  rqff_pkg::rqff_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rqff_pkg::CFG_LOW_QUALITY_CHAR: cfg_d.low_quality_char = cfg_data_i[7:0];
        rqff_pkg::CFG_REJECT_SCALE:     cfg_d.reject_scale     = cfg_data_i[7:0];
        rqff_pkg::CFG_MIN_FRAGMENT_LEN: cfg_d.min_fragment_len = cfg_data_i[8:0];
        rqff_pkg::CFG_SPLIT_CHAR:       cfg_d.split_char       = cfg_data_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_quality_char <= 8'd53;
      cfg_q.reject_scale     <= 8'd10;
      cfg_q.min_fragment_len <= 9'd29;
      cfg_q.split_char       <= 8'd78;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Front to back wiring: fragment table writes, the summary queue and the
  // bank handback that lets the front reuse a bank.
  rqff_pkg::rqff_frag_wr_t frag_wr;
  rqff_pkg::rqff_summary_t sum_in, sum_out;
  rqff_pkg::rqff_release_t bank_release;
  rqff_pkg::rqff_result_t  result;
  logic                    sum_push, sum_pop, sum_valid;

  rqff_front #(
    .MAX_READ  (MAX_READ),
    .MAX_FRAGS (MAX_FRAGS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push_i         (push),
    .full_o         (full),
    .base_char_i    (base_char_i),
    .quality_char_i (quality_char_i),
    .read_end_i     (read_end_i),
    .frag_wr_o      (frag_wr),
    .sum_push_o     (sum_push),
    .sum_o          (sum_in),
    .release_i      (bank_release)
  );

  rqff_sum_fifo u_sum_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sum_push),
    .data_i  (sum_in),
    .pop_i   (sum_pop),
    .valid_o (sum_valid),
    .data_o  (sum_out)
  );

  rqff_back #(
    .MAX_FRAGS (MAX_FRAGS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frag_wr_i   (frag_wr),
    .sum_valid_i (sum_valid),
    .sum_i       (sum_out),
    .sum_pop_o   (sum_pop),
    .release_o   (bank_release),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result)
  );

  assign verdict_o         = result.verdict;
  assign fragment_start_o  = result.start;
  assign fragment_length_o = result.length;
  assign last_of_read_o    = result.last;

endmodule
